// ===== sv/hfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Huffman tree loader and decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package hfd_pkg;

	localparam int MAX_NODES   = 511;
	localparam int STACK_DEPTH = 256;
	localparam int BYTE_BITS   = 8;
	localparam int SIZE_W      = 32;

	localparam int NODE_W   = $clog2(MAX_NODES);
	localparam int CNT_W    = $clog2(MAX_NODES + 1);
	localparam int STK_AW   = $clog2(STACK_DEPTH);
	localparam int SP_W     = $clog2(STACK_DEPTH + 1);
	localparam int STK_EW   = NODE_W + 1;
	localparam int BUDGET_W = SIZE_W + 3;
	localparam int IDX_W    = $clog2(BYTE_BITS + 1);
	localparam int INFO_W   = BYTE_BITS + 1;
	localparam int TDATA_W  = BYTE_BITS + SIZE_W;

	localparam logic [BYTE_BITS-1:0] LEAF_TOKEN = 8'h31;

	typedef enum logic [1:0] {
		OP_TREE = 2'd0,
		OP_DATA = 2'd1,
		OP_SEG  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK         = 2'd0,
		ERR_OVERFLOW   = 2'd1,
		ERR_INCOMPLETE = 2'd2,
		ERR_EXTRA      = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		PH_TOKEN  = 2'd0,
		PH_SYMBOL = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [NODE_W-1:0]    left;
		logic [NODE_W-1:0]    right;
		logic                 leaf;
		logic [BYTE_BITS-1:0] sym;
	} node_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic tree_sym;
		logic stk_rd;
		logic link;
		logic push;
		logic seg;
		logic fetch_root;
		logic fetch_cur;
		logic bit_first;
		logic bit_step;
		logic flush;
		logic err;
		err_t err_code;
	} hfd_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		op_t    op;
		phase_t phase;
		logic   full;
		logic   leaf_tok;
		logic   need_pop;
		logic   stk_ovf;
		logic   budget_zero;
		logic   more;
		logic   step_stall;
		logic   flush_stall;
		logic   out_free;
	} hfd_status_t;

endpackage

// ===== sv/huffman_tree_load_and_decode.sv =====
`timescale 1ns / 1ps
// Huffman decoder with a tree loaded from a pre-order byte stream.
// A tree byte passes through decode and, as needed, pop, link and push; a data byte first
// fetches the root and the current node, then makes one node-table read per budgeted bit.
// Throughput: one request at a time; the next is taken in the cycle after it finishes.
// Results leave through a one-entry output register; a full register stalls the walk.
// Reset clears all control state asynchronously; node tables and the pending stack
// are not cleared and are valid only once written by tree loading.
module huffman_tree_load_and_decode (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [7:0] data_byte, [39:8] segment_size
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] symbol
	output logic        m_axis_tlast,   // is_last
	output logic [1:0]  m_axis_tuser    // [1:0] error_code
);

	import hfd_pkg::*;

	hfd_cmd_t    cmd;
	hfd_status_t status;

	// The controller takes one request at a time: it is ready only in its idle
	// state, and a request runs to completion before the next one is taken. The
	// output register lets a new request start while the last result still waits.
	hfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the node tables, the pending-slot stack used while the
	// tree is built, the bit budget and walk position, and the result register.
	hfd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_user  (m_axis_tuser)
	);

endmodule

// ===== sv/hfd_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; no package needed.
module hfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/hfd_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences tree loading, segment setup and the
// bit-serial decode walk. Depends on hfd_pkg for the command and status types.
module hfd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hfd_pkg::hfd_status_t status,
	output hfd_pkg::hfd_cmd_t    cmd
);

	import hfd_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE       = 11'b000_0000_0001,
		S_DECODE     = 11'b000_0000_0010,
		S_POP        = 11'b000_0000_0100,
		S_LINK       = 11'b000_0000_1000,
		S_PUSH       = 11'b000_0001_0000,
		S_FETCH_ROOT = 11'b000_0010_0000,
		S_FETCH_CUR  = 11'b000_0100_0000,
		S_BIT_FIRST  = 11'b000_1000_0000,
		S_BIT        = 11'b001_0000_0000,
		S_FLUSH      = 11'b010_0000_0000,
		S_ERR        = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	err_t   err_q, err_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		err_d        = err_q;
		cmd          = '0;
		cmd.err_code = err_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.op)
					OP_TREE: begin
						if (status.phase == PH_DONE) begin
							err_d   = ERR_EXTRA;
							state_d = S_ERR;
						end else if (status.phase == PH_SYMBOL) begin
							cmd.tree_sym = 1'b1;
							state_d      = S_IDLE;
						end else if (status.full || (!status.leaf_tok && status.stk_ovf)) begin
							err_d   = ERR_OVERFLOW;
							state_d = S_ERR;
						end else if (status.need_pop) begin
							state_d = S_POP;
						end else begin
							state_d = S_LINK;
						end
					end
					OP_DATA: begin
						if (status.phase != PH_DONE) begin
							err_d   = ERR_INCOMPLETE;
							state_d = S_ERR;
						end else if (status.budget_zero) begin
							state_d = S_IDLE;
						end else begin
							state_d = S_FETCH_ROOT;
						end
					end
					OP_SEG: begin
						cmd.seg = 1'b1;
						state_d = S_IDLE;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_POP: begin
				cmd.stk_rd = 1'b1;
				state_d    = S_LINK;
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_d  = status.leaf_tok ? S_IDLE : S_PUSH;
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_IDLE;
			end
			S_FETCH_ROOT: begin
				cmd.fetch_root = 1'b1;
				state_d        = S_FETCH_CUR;
			end
			S_FETCH_CUR: begin
				cmd.fetch_cur = 1'b1;
				state_d       = S_BIT_FIRST;
			end
			S_BIT_FIRST: begin
				cmd.bit_first = 1'b1;
				state_d       = S_BIT;
			end
			S_BIT: begin
				cmd.bit_step = 1'b1;
				if (!status.step_stall && !status.more) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				if (!status.flush_stall) begin
					state_d = S_IDLE;
				end
			end
			S_ERR: begin
				cmd.err = 1'b1;
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= ERR_OK;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

endmodule

// ===== sv/hfd_dp.sv =====
`timescale 1ns / 1ps
// Datapath: node tables, pending stack, load and walk registers, result register.
// Depends on hfd_pkg and instantiates hfd_ram for every table.
module hfd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hfd_pkg::hfd_cmd_t               cmd,
	output hfd_pkg::hfd_status_t            status,
	input  logic [hfd_pkg::TDATA_W-1:0]     in_data,
	input  logic [1:0]                      in_user,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [hfd_pkg::BYTE_BITS-1:0]   out_data,
	output logic                            out_last,
	output logic [1:0]                      out_user
);

	import hfd_pkg::*;

	// Captured item.
	op_t                  op_q;
	logic [BYTE_BITS-1:0] byte_q;
	logic [SIZE_W-1:0]    size_q;

	// Load state.
	logic [CNT_W-1:0] nodes_q;
	logic [SP_W-1:0]  sp_q;
	phase_t           phase_q;

	// Walk state.
	logic [NODE_W-1:0]   walk_q;
	logic [BUDGET_W-1:0] bits_q;
	logic [IDX_W-1:0]    bit_idx_q;
	logic [NODE_W-1:0]   nxt_q;
	node_word_t          root_q;

	// Held symbol and result register.
	logic                 held_v_q;
	logic [BYTE_BITS-1:0] held_sym_q;
	logic                 out_v_q;
	logic [BYTE_BITS-1:0] out_sym_q;
	logic                 out_last_q;
	err_t                 out_err_q;

	// Memory ports.
	logic [NODE_W-1:0] left_rd, right_rd;
	logic [INFO_W-1:0] info_rd;
	logic [STK_EW-1:0] stk_rd;
	logic              node_re;
	logic [NODE_W-1:0] node_raddr;
	logic              left_we, right_we, info_we, stk_we;
	logic [NODE_W-1:0] child_waddr, info_waddr;
	logic [INFO_W-1:0] info_wdata;
	logic [STK_AW-1:0] stk_waddr, stk_raddr;
	logic [STK_EW-1:0] stk_wdata;

	// Combinational helpers.
	node_word_t        rd_word, cur_w;
	logic [NODE_W-1:0] cur_idx, child, next_idx, n_idx, parent;
	logic              bit_val, leaf_tok, need_pop, stk_ovf, more;
	logic              out_free, step_stall, flush_stall, step_go, issue;
	logic [SP_W-1:0]   after_pop;

	assign n_idx    = nodes_q[NODE_W-1:0];
	assign leaf_tok = (byte_q == LEAF_TOKEN);
	assign need_pop = (nodes_q != '0) && (sp_q != '0);
	assign after_pop = need_pop ? (sp_q - SP_W'(1)) : sp_q;
	assign stk_ovf  = ({1'b0, after_pop} + (SP_W + 1)'(2)) > (SP_W + 1)'(STACK_DEPTH);
	assign more     = (bit_idx_q != IDX_W'(BYTE_BITS)) && (bits_q != '0);
	assign out_free = !out_v_q || out_ready;

	assign rd_word = '{left: left_rd, right: right_rd, leaf: info_rd[INFO_W-1],
		sym: info_rd[BYTE_BITS-1:0]};

	assign step_stall  = rd_word.leaf && held_v_q && !out_free;
	assign flush_stall = held_v_q && !out_free;
	assign step_go     = cmd.bit_step && !step_stall;
	assign issue       = cmd.bit_first || (step_go && more);

	// Current node for the coming bit: after a leaf the walk restarts at the root.
	// The first bit of every byte is bit zero.
	always_comb begin
		if (cmd.bit_first) begin
			cur_w   = rd_word;
			cur_idx = walk_q;
		end else if (rd_word.leaf) begin
			cur_w   = root_q;
			cur_idx = '0;
		end else begin
			cur_w   = rd_word;
			cur_idx = nxt_q;
		end
		bit_val = cmd.bit_first ? byte_q[0] : byte_q[bit_idx_q[$clog2(BYTE_BITS)-1:0]];
		if (cur_w.leaf) begin
			child = cur_idx;
		end else begin
			child = bit_val ? cur_w.right : cur_w.left;
		end
		next_idx = ({1'b0, child} >= (NODE_W + 1)'(MAX_NODES)) ? '0 : child;
	end

	assign node_re    = cmd.fetch_root || cmd.fetch_cur || issue;
	assign node_raddr = cmd.fetch_root ? '0 : (cmd.fetch_cur ? walk_q : next_idx);

	// Linking a new node writes the waiting child slot of its parent.
	assign parent      = stk_rd[STK_EW-1:1];
	assign child_waddr = parent;
	assign left_we     = cmd.link && need_pop && !stk_rd[0];
	assign right_we    = cmd.link && need_pop && stk_rd[0];

	assign info_we    = (cmd.tree_sym && (nodes_q != '0)) || cmd.link;
	assign info_waddr = cmd.tree_sym ? (nodes_q - CNT_W'(1)) : n_idx;
	assign info_wdata = cmd.tree_sym ? {1'b1, byte_q} : {leaf_tok, {BYTE_BITS{1'b0}}};

	// Right slot goes on first so the left slot is popped first.
	assign stk_we    = (cmd.link && !leaf_tok) || cmd.push;
	assign stk_waddr = cmd.push ? sp_q[STK_AW-1:0] : after_pop[STK_AW-1:0];
	assign stk_wdata = cmd.push ? {n_idx, 1'b0} : {n_idx, 1'b1};
	assign stk_raddr = after_pop[STK_AW-1:0];

	hfd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_left (
		.clk(clk), .we(left_we), .waddr(child_waddr), .wdata(n_idx),
		.re(node_re), .raddr(node_raddr), .rdata(left_rd)
	);

	hfd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_right (
		.clk(clk), .we(right_we), .waddr(child_waddr), .wdata(n_idx),
		.re(node_re), .raddr(node_raddr), .rdata(right_rd)
	);

	hfd_ram #(.WIDTH(INFO_W), .DEPTH(MAX_NODES)) u_info (
		.clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
		.re(node_re), .raddr(node_raddr), .rdata(info_rd)
	);

	hfd_ram #(.WIDTH(STK_EW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(cmd.stk_rd), .raddr(stk_raddr), .rdata(stk_rd)
	);

	// Item and walk payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(in_user);
			byte_q <= in_data[BYTE_BITS-1:0];
			size_q <= in_data[TDATA_W-1:BYTE_BITS];
		end
		if (cmd.fetch_cur) begin
			root_q <= rd_word;
		end
		if (issue) begin
			nxt_q     <= next_idx;
			bit_idx_q <= cmd.bit_first ? IDX_W'(1) : (bit_idx_q + IDX_W'(1));
		end
		if (step_go && rd_word.leaf) begin
			held_sym_q <= rd_word.sym;
		end
	end

	// Load and walk control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q  <= '0;
			sp_q     <= '0;
			phase_q  <= PH_TOKEN;
			walk_q   <= '0;
			bits_q   <= '0;
			held_v_q <= 1'b0;
		end else begin
			if (cmd.tree_sym) begin
				phase_q <= (sp_q == '0) ? PH_DONE : PH_TOKEN;
			end
			if (cmd.link) begin
				if (leaf_tok) begin
					nodes_q <= nodes_q + CNT_W'(1);
					phase_q <= PH_SYMBOL;
					sp_q    <= after_pop;
				end else begin
					sp_q <= after_pop + SP_W'(1);
				end
			end
			if (cmd.push) begin
				sp_q    <= sp_q + SP_W'(1);
				nodes_q <= nodes_q + CNT_W'(1);
			end
			if (cmd.seg) begin
				bits_q <= {size_q, 3'b000};
				walk_q <= '0;
			end
			if (issue) begin
				bits_q <= bits_q - BUDGET_W'(1);
			end
			if (step_go) begin
				walk_q <= rd_word.leaf ? '0 : nxt_q;
				if (rd_word.leaf) begin
					held_v_q <= 1'b1;
				end
			end
			if (cmd.flush && !flush_stall) begin
				held_v_q <= 1'b0;
			end
		end
	end

	// Result register; a symbol is held back one place so the last one can be marked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (step_go && rd_word.leaf && held_v_q) begin
			out_v_q <= 1'b1;
		end else if (cmd.flush && held_v_q && out_free) begin
			out_v_q <= 1'b1;
		end else if (cmd.err && out_free) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && rd_word.leaf && held_v_q) begin
			out_sym_q  <= held_sym_q;
			out_last_q <= 1'b0;
			out_err_q  <= ERR_OK;
		end else if (cmd.flush && held_v_q && out_free) begin
			out_sym_q  <= held_sym_q;
			out_last_q <= 1'b1;
			out_err_q  <= ERR_OK;
		end else if (cmd.err && out_free) begin
			out_sym_q  <= '0;
			out_last_q <= 1'b1;
			out_err_q  <= cmd.err_code;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_sym_q;
	assign out_last  = out_last_q;
	assign out_user  = out_err_q;

	assign status = '{
		op:          op_q,
		phase:       phase_q,
		full:        (nodes_q >= CNT_W'(MAX_NODES)),
		leaf_tok:    leaf_tok,
		need_pop:    need_pop,
		stk_ovf:     stk_ovf,
		budget_zero: (bits_q == '0),
		more:        more,
		step_stall:  step_stall,
		flush_stall: flush_stall,
		out_free:    out_free
	};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for huffman_tree_load_and_decode: loads one code tree, then decodes.
// Depends on hfd_pkg and the block itself; expected symbols come from a predictor kept here.
module testbench;

	import hfd_pkg::*;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         SETTLE_CYCLES = 20;
	localparam int         LIMIT_CYCLES = 50000;
	localparam int         RANDOM_REQUESTS = 45;
	localparam int         SPINE_INTERNALS = 7;

	typedef struct {
		logic [BYTE_BITS-1:0] sym;
		logic                 last;
		err_t                 err;
	} symbol_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;     // [7:0] data_byte, [39:8] segment_size
	logic [1:0]  s_axis_tuser = '0;     // [1:0] op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;          // [7:0] symbol
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;          // [1:0] error_code

	// Predictor copy of the decoder state.
	logic [NODE_W-1:0]    code_left    [MAX_NODES] = '{default: '0};
	logic [NODE_W-1:0]    code_right   [MAX_NODES] = '{default: '0};
	logic                 code_is_leaf [MAX_NODES] = '{default: 1'b0};
	logic [BYTE_BITS-1:0] code_symbol  [MAX_NODES] = '{default: '0};
	logic [STK_EW-1:0]    pend_slots   [STACK_DEPTH] = '{default: '0};
	logic [CNT_W-1:0]     nodes_loaded = '0;
	logic [SP_W-1:0]      slot_count = '0;
	phase_t               load_phase = PH_TOKEN;
	logic [NODE_W-1:0]    walk_pos = '0;
	logic [BUDGET_W-1:0]  bit_budget = '0;

	symbol_rec_t expected_symbols[$];

	bit steady_in = 1'b0;
	bit steady_out = 1'b0;
	bit hold_request = 1'b0;
	bit single_leaf_tree;
	int failures = 0;
	int cycle_count = 0;
	int tree_reqs = 0, data_reqs = 0, seg_reqs = 0, unused_reqs = 0;
	int symbols_checked = 0, errors_checked = 0;

	huffman_tree_load_and_decode dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void expect_result(input logic [BYTE_BITS-1:0] sym, input logic last,
			input err_t err);
		symbol_rec_t rec;
		rec.sym = sym;
		rec.last = last;
		rec.err = err;
		expected_symbols.push_back(rec);
	endfunction

	// A new node takes the child slot that sits on top of the pending stack.
	function automatic void attach_node(input logic [CNT_W-1:0] n);
		logic [STK_EW-1:0] slot;
		if (n != 0 && slot_count != 0) begin
			slot_count = slot_count - 1'b1;
			slot = pend_slots[slot_count];
			if (slot[0])
				code_right[slot[STK_EW-1:1]] = n[NODE_W-1:0];
			else
				code_left[slot[STK_EW-1:1]] = n[NODE_W-1:0];
		end
	endfunction

	// Updates the predicted state for one accepted request and queues its results.
	function automatic void predict_request(input logic [1:0] op, input logic [7:0] b,
			input logic [31:0] size);
		logic [CNT_W-1:0]     n;
		logic [SP_W-1:0]      after_pop;
		logic [NODE_W-1:0]    cur, nxt;
		logic [BYTE_BITS-1:0] syms [BYTE_BITS];
		int k;
		k = 0;
		n = nodes_loaded;
		case (op)
			OP_TREE: begin
				if (load_phase == PH_DONE) begin
					expect_result('0, 1'b1, ERR_EXTRA);
				end else if (load_phase == PH_SYMBOL) begin
					code_symbol[n - 1'b1] = b;
					load_phase = (slot_count == 0) ? PH_DONE : PH_TOKEN;
				end else if (n >= MAX_NODES) begin
					expect_result('0, 1'b1, ERR_OVERFLOW);
				end else if (b == LEAF_TOKEN) begin
					attach_node(n);
					code_is_leaf[n] = 1'b1;
					code_left[n] = '0;
					code_right[n] = '0;
					nodes_loaded = n + 1'b1;
					load_phase = PH_SYMBOL;
				end else begin
					after_pop = (n != 0 && slot_count != 0) ? slot_count - 1'b1 : slot_count;
					if (int'(after_pop) + 2 > STACK_DEPTH) begin
						expect_result('0, 1'b1, ERR_OVERFLOW);
					end else begin
						attach_node(n);
						code_is_leaf[n] = 1'b0;
						code_symbol[n] = '0;
						pend_slots[slot_count] = {n[NODE_W-1:0], 1'b1};
						pend_slots[slot_count + 1] = {n[NODE_W-1:0], 1'b0};
						slot_count = slot_count + 2'd2;
						nodes_loaded = n + 1'b1;
					end
				end
			end
			OP_DATA: begin
				if (load_phase != PH_DONE) begin
					expect_result('0, 1'b1, ERR_INCOMPLETE);
				end else begin
					// One tree step per bit, LSB first, while budget remains.
					for (int i = 0; i < BYTE_BITS && bit_budget != 0; i++) begin
						cur = walk_pos;
						if (code_is_leaf[cur])
							nxt = cur;
						else
							nxt = b[i] ? code_right[cur] : code_left[cur];
						if (nxt >= MAX_NODES)
							nxt = '0;
						if (code_is_leaf[nxt]) begin
							syms[k] = code_symbol[nxt];
							k++;
							walk_pos = '0;
						end else begin
							walk_pos = nxt;
						end
						bit_budget = bit_budget - 1'b1;
					end
					for (int j = 0; j < k; j++)
						expect_result(syms[j], j == k - 1, ERR_OK);
				end
			end
			OP_SEG: begin
				bit_budget = {size, 3'b000};
				walk_pos = '0;
			end
			default: ;
		endcase
	endfunction

	// Offers one request, waits for it to be taken and predicts its results.
	// tvalid stays high afterwards so that a back-to-back request needs no toggle.
	task automatic send_request(input logic [1:0] op, input logic [7:0] b, input logic [31:0] size);
		int gap;
		gap = steady_in ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {size, b};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_request(op, b, size);
		case (op)
			OP_TREE: tree_reqs++;
			OP_DATA: data_reqs++;
			OP_SEG:  seg_reqs++;
			default: unused_reqs++;
		endcase
	endtask

	// Stops offering and waits for every expected result plus the block's latency.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_symbols.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Before any tree exists: a data byte is refused, a segment only arms the budget.
	task automatic test_early_requests();
		send_request(OP_DATA, 8'hFF, 32'hFFFF_FFFF);
		send_request(OP_SEG, 8'h00, 32'd3);
		send_request(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
		send_request(OP_DATA, 8'h00, 32'd0);
		settle();
	endtask

	// Most runs load a lopsided tree: a run of internal tokens builds a left spine, and the
	// leaves that follow fill the deepest slot first and then every right slot on the way up.
	// Now and then the tree is a single leaf instead, which decodes every bit to one symbol.
	task automatic test_tree_load();
		logic [7:0] tok, sym;
		if (single_leaf_tree) begin
			send_request(OP_TREE, LEAF_TOKEN, $urandom);
			send_request(OP_DATA, 8'hA5, $urandom);
			send_request(OP_TREE, 8'($urandom_range(0, 255)), $urandom);
		end else begin
			for (int i = 0; i < SPINE_INTERNALS; i++) begin
				case (i)
					0: tok = 8'h00;
					1: tok = 8'hFF;
					2: tok = LEAF_TOKEN - 1'b1;
					3: tok = LEAF_TOKEN + 1'b1;
					default: tok = 8'($urandom_range(0, 255));
				endcase
				if (tok == LEAF_TOKEN)
					tok = ~tok;
				send_request(OP_TREE, tok, $urandom);
				if (i == 2)
					send_request(OP_DATA, 8'($urandom_range(0, 255)), $urandom);
			end
			for (int i = 0; i <= SPINE_INTERNALS; i++) begin
				case (i)
					0: sym = LEAF_TOKEN;
					1: sym = 8'h00;
					2: sym = 8'hFF;
					default: sym = 8'($urandom_range(0, 255));
				endcase
				send_request(OP_TREE, LEAF_TOKEN, $urandom);
				if (i == 0)
					send_request(OP_DATA, 8'($urandom_range(0, 255)), $urandom);
				send_request(OP_TREE, sym, $urandom);
			end
		end
		settle();
	endtask

	task automatic test_extra_tree_bytes();
		send_request(OP_TREE, LEAF_TOKEN, $urandom);
		send_request(OP_TREE, 8'h00, $urandom);
		send_request(OP_TREE, 8'hFF, $urandom);
		settle();
	endtask

	// The budget armed before the tree was done still holds three bytes; the fourth is dropped.
	task automatic test_segment_budget();
		send_request(OP_DATA, 8'h5A, $urandom);
		send_request(OP_DATA, 8'hA5, $urandom);
		send_request(OP_DATA, 8'hFF, $urandom);
		send_request(OP_DATA, 8'hFF, $urandom);
		send_request(OP_SEG, 8'hFF, 32'd0);
		send_request(OP_DATA, 8'hFF, $urandom);
		send_request(OP_SEG, 8'h00, 32'hFFFF_FFFF);
		send_request(OP_DATA, 8'hFF, $urandom);
		// All zeros walk down the left spine to the deepest leaf.
		for (int i = 0; i < 2; i++)
			send_request(OP_DATA, 8'h00, $urandom);
		send_request(OP_DATA, 8'h80, $urandom);
		// A new segment in the middle of a path sends the walk back to the root.
		send_request(OP_SEG, 8'h00, 32'd1);
		send_request(OP_DATA, 8'h00, $urandom);
		send_request(OP_SEG, 8'h00, 32'd2);
		send_request(OP_DATA, 8'h6D, $urandom);
		send_request(OP_DATA, 8'h92, $urandom);
		send_request(OP_DATA, 8'hFF, $urandom);
		settle();
	endtask

	// The result side stops for a long stretch while requests keep coming back to back.
	task automatic test_backpressure();
		steady_in = 1'b1;
		send_request(OP_SEG, 8'h00, 32'd64);
		hold_request = 1'b1;
		for (int i = 0; i < 16; i++)
			send_request(OP_DATA, 8'($urandom_range(0, 255)), $urandom);
		steady_in = 1'b0;
		settle();
	endtask

	// Mostly data bytes under short segments, with a zero or a full 32-bit random size now and then,
	// plus stray tree bytes and unused ops as noise.
	task automatic test_random_traffic();
		int pick;
		logic [31:0] size;
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 16 == 0) begin
				steady_in = ($urandom_range(0, 3) == 0);
				steady_out = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				send_request(OP_DATA, 8'($urandom_range(0, 255)), $urandom);
			end else if (pick < 86) begin
				case ($urandom_range(0, 9))
					0: size = 32'd0;
					1: size = $urandom;
					default: size = $urandom_range(1, 12);
				endcase
				send_request(OP_SEG, 8'($urandom_range(0, 255)), size);
			end else if (pick < 94) begin
				send_request(OP_TREE, 8'($urandom_range(0, 255)), $urandom);
			end else begin
				send_request(OP_UNUSED, 8'($urandom_range(0, 255)), $urandom);
			end
		end
		steady_in = 1'b0;
		steady_out = 1'b0;
		settle();
	endtask

	// Result sink: random stalls before each result, plus the long hold when asked for.
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			stall = steady_out ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		symbol_rec_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_symbols.size() == 0) begin
				$error("result with nothing expected: symbol %0h last %0b error %0d",
					m_axis_tdata, m_axis_tlast, m_axis_tuser);
				failures++;
			end else begin
				want = expected_symbols.pop_front();
				if (want.err == ERR_OK)
					symbols_checked++;
				else
					errors_checked++;
				if (m_axis_tdata !== want.sym) begin
					$error("symbol: expected %0h, got %0h", want.sym, m_axis_tdata);
					failures++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("is_last: expected %0b, got %0b", want.last, m_axis_tlast);
					failures++;
				end
				if (m_axis_tuser !== want.err) begin
					$error("error_code: expected %0d, got %0d", want.err, m_axis_tuser);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		single_leaf_tree = ($urandom_range(0, 7) == 0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_early_requests();
		test_tree_load();
		test_extra_tree_bytes();
		test_segment_budget();
		test_backpressure();
		test_random_traffic();
		$display("Decoded with a %s tree: %0d tree, %0d data, %0d segment, %0d unused requests;",
			single_leaf_tree ? "single-leaf" : "left-spine", tree_reqs, data_reqs, seg_reqs,
			unused_reqs);
		$display("compared %0d decoded symbols and %0d error results.", symbols_checked,
			errors_checked);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/hfd_pkg.sv
sv/hfd_ram.sv
sv/hfd_ctrl.sv
sv/hfd_dp.sv
sv/huffman_tree_load_and_decode.sv
verif/testbench.sv
